FILE: src/afkn_pkg.sv
`timescale 1ns / 1ps

package afkn_pkg;

   // UTF-8 lead byte of the Latin-1 supplement letters
   localparam logic [7:0] LEAD_BYTE = 8'hC3;

   // ASCII codes used by the key filter
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Result queue sizing
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // One result word
   typedef struct packed {
      logic [6:0] out_char;
      logic       has_char;
      logic       last;
   } rsp_word_type;

   // Plain letter for the low five bits of a follower byte; zero when not listed
   function automatic logic [6:0] fold_letter(input logic [4:0] low_bits);
      logic [6:0] letter;
      unique case (low_bits)
         5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06: letter = 7'h41; // A
         5'h07:                                          letter = 7'h43; // C
         5'h08, 5'h09, 5'h0A, 5'h0B:                     letter = 7'h45; // E
         5'h0C, 5'h0D, 5'h0E, 5'h0F:                     letter = 7'h49; // I
         5'h11:                                          letter = 7'h4E; // N
         5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h18:       letter = 7'h4F; // O
         5'h19, 5'h1A, 5'h1B, 5'h1C:                     letter = 7'h55; // U
         5'h1D:                                          letter = 7'h59; // Y
         default:                                        letter = 7'h00;
      endcase
      return letter;
   endfunction

endpackage

FILE: src/accent_folding_key_normalizer_unit.sv
`timescale 1ns / 1ps

// Accent-folding search key normalizer.
//
// The req channel takes one byte of UTF-8 text per word, with req_end_of_text
// set on the final byte of a string. The rsp channel returns the key one
// character per word: A-Z, 0-9 or a single space, with rsp_last on the final
// word of the string. A string whose final byte yields no character closes
// with one bare word (rsp_has_char low, rsp_last high).
//
// A byte is taken every cycle while req_ready is high: the fold, case and
// space logic is one short pass that writes straight into a four-word result
// queue. A byte can yield two words (a held space and a character), but a
// held space always came from a byte that yielded nothing, so the output
// keeps pace at one word per cycle while the receiver is ready. req_ready
// drops only while fewer than two queue slots are free, which is where a
// stalled receiver pushes back on the sender.
//
// Synchronous reset empties the queue and clears the three string flags; the
// flags also clear after each end-of-text byte.
module accent_folding_key_normalizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   input  logic       req_valid,
   output logic       req_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_last,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   // String flags
   logic lead_seen_ff, lead_seen_in;
   logic space_pend_ff, space_pend_in;
   logic emitted_ff, emitted_in;

   // Result queue
   afkn_pkg::rsp_word_type               queue_ff [afkn_pkg::RSP_DEPTH];
   logic [afkn_pkg::RSP_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [afkn_pkg::RSP_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [afkn_pkg::RSP_CNT_W-1:0]       count_ff, count_in;

   logic                                 req_take;
   logic                                 rsp_take;
   logic                                 folded;
   logic [6:0]                           fold_char;
   logic [7:0]                           upper_byte;
   logic                                 keep_plain;
   logic [6:0]                           key_char;
   logic                                 has_key;
   logic                                 space_set;
   logic [1:0]                           push_num;
   afkn_pkg::rsp_word_type               word0;
   afkn_pkg::rsp_word_type               word1;
   afkn_pkg::rsp_word_type               head_word;

   assign req_ready = count_ff <= afkn_pkg::RSP_CNT_W'(afkn_pkg::RSP_DEPTH - 2);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_take  = rsp_valid && rsp_ready;

   // Classify the incoming byte
   always_comb begin
      fold_char  = afkn_pkg::fold_letter(req_in_byte[4:0]);
      folded     = lead_seen_ff && (req_in_byte[7:6] == 2'b10) && (fold_char != '0);
      upper_byte = req_in_byte;
      if (req_in_byte >= afkn_pkg::CHAR_LOWER_A && req_in_byte <= afkn_pkg::CHAR_LOWER_Z) begin
         upper_byte = req_in_byte - afkn_pkg::CASE_OFFSET;
      end
      keep_plain = (upper_byte >= afkn_pkg::CHAR_UPPER_A && upper_byte <= afkn_pkg::CHAR_UPPER_Z)
                || (upper_byte >= afkn_pkg::CHAR_DIGIT_0 && upper_byte <= afkn_pkg::CHAR_DIGIT_9);
      key_char   = folded ? fold_char : (keep_plain ? upper_byte[6:0] : 7'h00);
      has_key    = folded || keep_plain;
      space_set  = !has_key && (req_in_byte == afkn_pkg::CHAR_SPACE) && emitted_ff;
   end

   // Build result words and the next flag values
   always_comb begin
      word0    = '{out_char: key_char, has_char: 1'b1, last: req_end_of_text};
      word1    = word0;
      push_num = 2'd0;
      if (has_key) begin
         if (space_pend_ff) begin
            word0    = '{out_char: afkn_pkg::CHAR_SPACE[6:0], has_char: 1'b1, last: 1'b0};
            push_num = 2'd2;
         end else begin
            push_num = 2'd1;
         end
      end else if (req_end_of_text) begin
         word0    = '{out_char: 7'h00, has_char: 1'b0, last: 1'b1};
         push_num = 2'd1;
      end

      lead_seen_in  = !folded && (req_in_byte == afkn_pkg::LEAD_BYTE);
      space_pend_in = has_key ? 1'b0 : (space_pend_ff || space_set);
      emitted_in    = emitted_ff || has_key;
      if (req_end_of_text) begin
         lead_seen_in  = 1'b0;
         space_pend_in = 1'b0;
         emitted_in    = 1'b0;
      end
   end

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff + afkn_pkg::RSP_PTR_W'(rsp_take);
      count_in  = count_ff - afkn_pkg::RSP_CNT_W'(rsp_take);
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + afkn_pkg::RSP_PTR_W'(push_num);
         count_in  = count_in + afkn_pkg::RSP_CNT_W'(push_num);
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_seen_ff  <= 1'b0;
         space_pend_ff <= 1'b0;
         emitted_ff    <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_take) begin
            lead_seen_ff  <= lead_seen_in;
            space_pend_ff <= space_pend_in;
            emitted_ff    <= emitted_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write result words into the queue
   always_ff @(posedge clock) begin
      if (req_take && push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (req_take && push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + afkn_pkg::RSP_PTR_W'(1)] <= word1;
      end
   end

   // Present the queue head
   assign head_word    = queue_ff[rd_ptr_ff];
   assign rsp_out_char = head_word.out_char;
   assign rsp_has_char = head_word.has_char;
   assign rsp_last     = head_word.last;

endmodule

FILE: src/afkn_checker.sv
`timescale 1ns / 1ps

module afkn_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_has_char,
   input logic       rsp_last,
   input logic       rsp_valid,
   input logic       rsp_ready
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_has_char) && $stable(rsp_last))
      else $error("stalled rsp word changed");

   // Keep only key characters
   a_key_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_char |->
         (rsp_out_char >= 7'h41 && rsp_out_char <= 7'h5A)
         || (rsp_out_char >= 7'h30 && rsp_out_char <= 7'h39)
         || rsp_out_char == afkn_pkg::CHAR_SPACE[6:0])
      else $error("rsp word carries a non-key character");

   // Mark a bare word as the string end
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_last && rsp_out_char == 7'h00)
      else $error("bare rsp word without last");

   // Drop trailing spaces
   a_no_tail_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_char && rsp_out_char == afkn_pkg::CHAR_SPACE[6:0] |-> !rsp_last)
      else $error("string ends with a space");

   // Empty the queue at reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

endmodule

bind accent_folding_key_normalizer_unit afkn_checker u_afkn_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_has_char (rsp_has_char),
   .rsp_last     (rsp_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready)
);

FILE: sim/accent_folding_key_normalizer_unit_tb.sv
`timescale 1ns / 1ps

module accent_folding_key_normalizer_unit_tb;

   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_WORDS     = 615;
   localparam int DRAIN_CYCLES    = 8;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic [7:0] req_in_byte     = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [6:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_last;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;

   // Key state mirrored from the block
   logic lead_pending = 1'b0;
   logic space_held   = 1'b0;
   logic key_started  = 1'b0;

   afkn_pkg::rsp_word_type key_words_due[$];

   int  send_idle_pct  = 29;
   int  recv_idle_pct  = 45;
   bit  hold_request   = 1'b0;
   int  hold_left      = 0;
   int  bytes_sent     = 0;
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;

   accent_folding_key_normalizer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_has_char    (rsp_has_char),
      .rsp_last        (rsp_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Plain letter for a follower byte of 0xC3; zero when the pair is not listed
   function automatic logic [6:0] plain_letter(input logic [7:0] follower);
      logic [4:0] lo;
      lo = follower[4:0];
      if (follower < 8'h80 || follower > 8'hBF) return 7'h00;
      if (lo <= 5'd6)                          return 7'h41;
      if (lo == 5'd7)                          return 7'h43;
      if (lo <= 5'd11)                         return 7'h45;
      if (lo <= 5'd15)                         return 7'h49;
      if (lo == 5'd17)                         return 7'h4E;
      if ((lo >= 5'd18 && lo <= 5'd22) || lo == 5'd24) return 7'h4F;
      if (lo >= 5'd25 && lo <= 5'd28)          return 7'h55;
      if (lo == 5'd29)                         return 7'h59;
      return 7'h00;
   endfunction

   // Append one word to the tail of the expected list
   function automatic void expect_word(input afkn_pkg::rsp_word_type w);
      key_words_due = {key_words_due, w};
   endfunction

   // Work out the key words caused by one accepted byte
   function automatic void predict_key_words(input logic [7:0] b, input logic eot);
      logic [7:0]             c;
      logic [6:0]             letter;
      afkn_pkg::rsp_word_type w;
      c      = b;
      letter = 7'h00;
      if (lead_pending && plain_letter(b) != 7'h00) begin
         letter       = plain_letter(b);
         lead_pending = 1'b0;
      end else begin
         lead_pending = (b == afkn_pkg::LEAD_BYTE);
         if (c >= afkn_pkg::CHAR_LOWER_A && c <= afkn_pkg::CHAR_LOWER_Z)
            c = c - afkn_pkg::CASE_OFFSET;
         if ((c >= afkn_pkg::CHAR_UPPER_A && c <= afkn_pkg::CHAR_UPPER_Z) ||
             (c >= afkn_pkg::CHAR_DIGIT_0 && c <= afkn_pkg::CHAR_DIGIT_9)) begin
            letter = c[6:0];
         end else if (c == afkn_pkg::CHAR_SPACE && key_started) begin
            space_held = 1'b1;
         end
      end
      if (letter != 7'h00) begin
         // release the held space ahead of the character
         if (space_held) begin
            w.out_char = afkn_pkg::CHAR_SPACE[6:0];
            w.has_char = 1'b1;
            w.last     = 1'b0;
            expect_word(w);
         end
         space_held  = 1'b0;
         key_started = 1'b1;
         w.out_char  = letter;
         w.has_char  = 1'b1;
         w.last      = eot;
         expect_word(w);
      end else if (eot) begin
         w.out_char = 7'h00;
         w.has_char = 1'b0;
         w.last     = 1'b1;
         expect_word(w);
      end
      if (eot) begin
         lead_pending = 1'b0;
         space_held   = 1'b0;
         key_started  = 1'b0;
      end
   endfunction

   // Offer one byte, idling at random first, and hold it until accepted
   task automatic offer_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      predict_key_words(b, eot);
      bytes_sent++;
   endtask

   // Spaces, case, digits, dropped bytes, trailing space closed by a bare marker
   task automatic test_directed_plain_text();
      offer_byte(8'h20, 1'b0);
      offer_byte(8'h20, 1'b0);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h5A, 1'b0);
      offer_byte(8'h30, 1'b0);
      offer_byte(8'h20, 1'b0);
      offer_byte(8'h20, 1'b0);
      offer_byte(8'h39, 1'b0);
      offer_byte(8'h09, 1'b0);
      offer_byte(8'h2F, 1'b0);
      offer_byte(8'h0A, 1'b0);
      offer_byte(8'h00, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h20, 1'b1);
   endtask

   // Folded pairs, unlisted followers, repeated lead bytes, dangling lead at end
   task automatic test_directed_accent_pairs();
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(8'h80, 1'b0);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(8'hBD, 1'b0);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(8'h91, 1'b0);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(8'h41, 1'b0);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b0);
      offer_byte(8'h97, 1'b0);
      offer_byte(8'h7A, 1'b1);
      offer_byte(afkn_pkg::LEAD_BYTE, 1'b1);
   endtask

   // One string of random tokens, mostly well-formed text
   task automatic send_random_string();
      logic [7:0] text[$];
      int         tokens;
      int         pick;
      logic [7:0] f;
      tokens = $urandom_range(16, 1);
      repeat (tokens) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            text = {text, 8'($urandom_range(afkn_pkg::CHAR_LOWER_Z, afkn_pkg::CHAR_LOWER_A))};
         end else if (pick < 40) begin
            text = {text, 8'($urandom_range(afkn_pkg::CHAR_UPPER_Z, afkn_pkg::CHAR_UPPER_A))};
         end else if (pick < 50) begin
            text = {text, 8'($urandom_range(afkn_pkg::CHAR_DIGIT_9, afkn_pkg::CHAR_DIGIT_0))};
         end else if (pick < 65) begin
            text = {text, afkn_pkg::CHAR_SPACE};
         end else if (pick < 85) begin
            do f = 8'($urandom_range(8'hBF, 8'h80)); while (plain_letter(f) == 7'h00);
            text = {text, afkn_pkg::LEAD_BYTE, f};
         end else if (pick < 92) begin
            text = {text, afkn_pkg::LEAD_BYTE, 8'($urandom_range(255))};
         end else begin
            text = {text, 8'($urandom_range(255))};
         end
      end
      foreach (text[i]) offer_byte(text[i], i == text.size() - 1);
   endtask

   // Random strings under one idling setting, optionally with a long receiver hold-off
   task automatic test_random_text(input int s_pct, input int r_pct, input bit hold_off);
      int first;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      first         = bytes_sent;
      if (hold_off) hold_request = 1'b1;
      while (bytes_sent - first < PHASE_WORDS) send_random_string();
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_OFF_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result word with the oldest expected one
   always @(posedge clock) begin : check_words
      afkn_pkg::rsp_word_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (key_words_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: char=%h has=%b last=%b",
                        rsp_out_char, rsp_has_char, rsp_last);
            mismatch_count++;
         end else begin
            due = key_words_due.pop_front();
            if (due.out_char !== rsp_out_char || due.has_char !== rsp_has_char ||
                due.last !== rsp_last) begin
               if (mismatch_count < 10)
                  $display({"word mismatch: expected char=%h has=%b last=%b, ",
                            "got char=%h has=%b last=%b"},
                           due.out_char, due.has_char, due.last,
                           rsp_out_char, rsp_has_char, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else if (!reset) begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_plain_text();
      test_directed_accent_pairs();
      test_random_text(29, 45, 1'b0);
      test_random_text(45, 29, 1'b0);
      test_random_text(0, 0, 1'b1);
      req_valid <= 1'b0;
      // drain, then allow for any stray words
      while (key_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && key_words_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
